// File: sv/smpte_timecode_counter_defines.svh
// Assertion macros shared by the timecode counter checker.
`ifndef SMPTE_TIMECODE_COUNTER_DEFINES_SVH
`define SMPTE_TIMECODE_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timecode counter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timecode counter check failed");

`endif

// File: sv/stc_pkg.sv
// Types and constants shared by the timecode counter modules.
package stc_pkg;

	typedef enum logic [2:0] {
		KIND_LOAD      = 3'd0,
		KIND_FRAME_UP  = 3'd1,
		KIND_FRAME_DN  = 3'd2,
		KIND_SUB_UP    = 3'd3,
		KIND_SUB_DN    = 3'd4,
		KIND_NEXT_SEC  = 3'd5,
		KIND_NEXT_MIN  = 3'd6,
		KIND_NEXT_HOUR = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		REG_RATE_CLASS = 2'd0,
		REG_DROP_FRAME = 2'd1,
		REG_SUBFRAMES  = 2'd2
	} reg_idx_t;

	localparam logic [2:0] WRAP_NONE    = 3'd0;
	localparam logic [2:0] WRAP_FRAMES  = 3'd1;
	localparam logic [2:0] WRAP_SECONDS = 3'd2;
	localparam logic [2:0] WRAP_MINUTES = 3'd3;
	localparam logic [2:0] WRAP_HOURS   = 3'd4;

	localparam logic [1:0] RATE_30       = 2'd2;
	localparam logic [5:0] LAST_SECOND   = 6'd59;
	localparam logic [5:0] LAST_MINUTE   = 6'd59;
	localparam logic [7:0] LAST_HOUR     = 8'd255;
	localparam logic [5:0] DROP_COUNT    = 6'd2;
	localparam logic [5:0] DROP_LAST     = 6'd29;
	localparam logic [5:0] LAST_FRAME [0:3] = '{6'd23, 6'd24, 6'd29, 6'd59};

	localparam logic [1:0] RST_RATE_CLASS = 2'd2;
	localparam logic       RST_DROP_FRAME = 1'b0;
	localparam logic [7:0] RST_SUBFRAMES  = 8'd80;

	typedef struct packed {
		logic [1:0] rate_class;
		logic       drop_frame;
		logic [7:0] subframe_span;
	} cfg_t;

	typedef struct packed {
		logic [7:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [5:0] frames;
		logic [7:0] subframes;
		logic       negative;
	} tc_t;

	typedef struct packed {
		tc_t        tc;
		logic [2:0] wrap_level;
	} res_t;

endpackage

// File: sv/stc_cfg.sv
// Configuration register file with its APB-style access port.
module stc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output stc_pkg::cfg_t       cfg
);
	import stc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_class    <= RST_RATE_CLASS;
			cfg_q.drop_frame    <= RST_DROP_FRAME;
			cfg_q.subframe_span <= RST_SUBFRAMES;
		end else if (wr_en) begin
			unique case (idx)
				REG_RATE_CLASS: cfg_q.rate_class <= pwdata[1:0];
				REG_DROP_FRAME: cfg_q.drop_frame <= pwdata[0];
				REG_SUBFRAMES:  cfg_q.subframe_span <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RATE_CLASS: prdata = {30'd0, cfg_q.rate_class};
			REG_DROP_FRAME: prdata = {31'd0, cfg_q.drop_frame};
			REG_SUBFRAMES:  prdata = {24'd0, cfg_q.subframe_span};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// File: sv/stc_step.sv
// Next-value logic: applies one command to the current timecode.
module stc_step (
	input  stc_pkg::kind_t kind,
	input  stc_pkg::tc_t   load_val,
	input  stc_pkg::tc_t   cur,
	input  stc_pkg::cfg_t  cfg,
	output stc_pkg::res_t  res
);
	import stc_pkg::*;

	function automatic logic mult_of_ten(input logic [6:0] v);
		logic r;
		r = 1'b0;
		for (int i = 0; i < 7; i++) begin
			if (v == 7'(10 * i)) begin
				r = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic dropping(input cfg_t c);
		return c.drop_frame && (c.rate_class == RATE_30);
	endfunction

	function automatic logic is_zero(input tc_t t);
		return ~|{t.hours, t.minutes, t.seconds, t.frames, t.subframes};
	endfunction

	function automatic logic near_zero(input tc_t t);
		return ~|{t.hours, t.minutes, t.seconds, t.frames};
	endfunction

	function automatic logic [2:0] mag_up(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		w = WRAP_NONE;
		priority if (t.frames < LAST_FRAME[c.rate_class]) begin
			t.frames = t.frames + 6'd1;
		end else if (t.seconds >= LAST_SECOND && t.minutes >= LAST_MINUTE &&
				t.hours == LAST_HOUR) begin
			w = WRAP_NONE;
		end else begin
			t.frames = (dropping(c) && !mult_of_ten({1'b0, t.minutes} + 7'd1) &&
				t.seconds >= LAST_SECOND) ? DROP_COUNT : 6'd0;
			if (t.seconds < LAST_SECOND) begin
				t.seconds = t.seconds + 6'd1;
				w = WRAP_SECONDS;
			end else begin
				t.seconds = 6'd0;
				if (t.minutes < LAST_MINUTE) begin
					t.minutes = t.minutes + 6'd1;
					w = WRAP_MINUTES;
				end else begin
					t.minutes = 6'd0;
					t.hours = t.hours + 8'd1;
					w = WRAP_HOURS;
				end
			end
		end
		return w;
	endfunction

	function automatic logic [2:0] mag_down(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		logic carry;
		w = WRAP_NONE;
		carry = 1'b0;
		priority if (dropping(c) && !mult_of_ten({1'b0, t.minutes}) && t.seconds == 6'd0) begin
			if (t.frames <= DROP_COUNT) begin
				t.frames = DROP_LAST;
				carry = 1'b1;
			end
		end else if (t.frames == 6'd0) begin
			t.frames = LAST_FRAME[c.rate_class];
			carry = 1'b1;
		end
		priority if (!carry) begin
			t.frames = t.frames - 6'd1;
		end else if (t.seconds != 6'd0) begin
			t.seconds = t.seconds - 6'd1;
			w = WRAP_SECONDS;
		end else begin
			t.seconds = LAST_SECOND;
			if (t.minutes != 6'd0) begin
				t.minutes = t.minutes - 6'd1;
				w = WRAP_MINUTES;
			end else begin
				t.minutes = LAST_MINUTE;
				t.hours = t.hours - 8'd1;
				w = WRAP_HOURS;
			end
		end
		return w;
	endfunction

	function automatic logic [2:0] frame_up(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		priority if (!t.negative) begin
			w = mag_up(t, c);
		end else if (near_zero(t) && t.subframes != 8'd0) begin
			t.subframes = c.subframe_span - t.subframes;
			t.negative = 1'b0;
			w = WRAP_SECONDS;
		end else if (is_zero(t)) begin
			w = mag_up(t, c);
			t.negative = 1'b1;
		end else begin
			w = mag_down(t, c);
			t.negative = !is_zero(t);
		end
		return w;
	endfunction

	function automatic logic [2:0] frame_down(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		priority if (t.negative || is_zero(t)) begin
			w = mag_up(t, c);
			t.negative = 1'b1;
		end else if (near_zero(t) && t.subframes != 8'd0) begin
			t.subframes = c.subframe_span - t.subframes;
			t.negative = 1'b1;
			w = WRAP_SECONDS;
		end else begin
			w = mag_down(t, c);
			if (is_zero(t)) begin
				t.negative = 1'b0;
			end
		end
		return w;
	endfunction

	function automatic logic [2:0] sub_up_pos(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		logic [8:0] n;
		n = {1'b0, t.subframes} + 9'd1;
		if (n >= {1'b0, c.subframe_span}) begin
			t.subframes = 8'd0;
			void'(mag_up(t, c));
			w = WRAP_FRAMES;
		end else begin
			t.subframes = n[7:0];
			w = WRAP_NONE;
		end
		return w;
	endfunction

	function automatic logic [2:0] sub_down_pos(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		priority if (t.subframes == 8'd0 && is_zero(t)) begin
			t.negative = 1'b1;
			t.subframes = 8'd1;
			w = WRAP_FRAMES;
		end else if (t.subframes == 8'd0) begin
			void'(mag_down(t, c));
			if (is_zero(t)) begin
				t.negative = 1'b0;
			end
			t.subframes = c.subframe_span - 8'd1;
			w = WRAP_FRAMES;
		end else begin
			t.subframes = t.subframes - 8'd1;
			if (is_zero(t)) begin
				t.negative = 1'b0;
			end
			w = WRAP_NONE;
		end
		return w;
	endfunction

	function automatic logic [2:0] sub_up(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		if (!t.negative) begin
			w = sub_up_pos(t, c);
		end else begin
			t.negative = 1'b0;
			w = sub_down_pos(t, c);
			if (!is_zero(t)) begin
				t.negative = 1'b1;
			end
		end
		return w;
	endfunction

	function automatic logic [2:0] sub_down(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		if (!t.negative) begin
			w = sub_down_pos(t, c);
		end else begin
			t.negative = 1'b0;
			w = sub_up_pos(t, c);
			t.negative = 1'b1;
		end
		return w;
	endfunction

	function automatic void clear_sub(inout tc_t t);
		t.subframes = 8'd0;
		if (is_zero(t)) begin
			t.negative = 1'b0;
		end
	endfunction

	function automatic void floor_second(inout tc_t t, input cfg_t c);
		clear_sub(t);
		t.frames = (dropping(c) && !mult_of_ten({1'b0, t.minutes}) &&
			t.seconds == 6'd0) ? DROP_COUNT : 6'd0;
		if (is_zero(t)) begin
			t.negative = 1'b0;
		end
	endfunction

	function automatic logic [2:0] next_second(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		clear_sub(t);
		if (t.negative) begin
			w = frame_up(t, c);
			floor_second(t, c);
			if (is_zero(t)) begin
				t.negative = 1'b0;
			end
		end else begin
			t.frames = LAST_FRAME[c.rate_class];
			w = mag_up(t, c);
		end
		return w;
	endfunction

	function automatic logic [2:0] next_minute(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		clear_sub(t);
		if (t.negative) begin
			w = next_second(t, c);
			t.seconds = 6'd0;
			floor_second(t, c);
		end else begin
			t.seconds = LAST_SECOND;
			w = next_second(t, c);
		end
		return w;
	endfunction

	function automatic logic [2:0] next_hour(inout tc_t t, input cfg_t c);
		logic [2:0] w;
		clear_sub(t);
		if (t.negative) begin
			w = next_minute(t, c);
			t.minutes = 6'd0;
			t.seconds = 6'd0;
			t.frames = 6'd0;
			t.subframes = 8'd0;
			if (is_zero(t)) begin
				t.negative = 1'b0;
			end
		end else begin
			t.minutes = LAST_MINUTE;
			w = next_minute(t, c);
		end
		return w;
	endfunction

	tc_t        t;
	logic [2:0] w;

	always_comb begin
		t = cur;
		w = WRAP_NONE;
		unique case (kind)
			KIND_LOAD:      t = load_val;
			KIND_FRAME_UP:  w = frame_up(t, cfg);
			KIND_FRAME_DN:  w = frame_down(t, cfg);
			KIND_SUB_UP:    w = sub_up(t, cfg);
			KIND_SUB_DN:    w = sub_down(t, cfg);
			KIND_NEXT_SEC:  w = next_second(t, cfg);
			KIND_NEXT_MIN:  w = next_minute(t, cfg);
			KIND_NEXT_HOUR: w = next_hour(t, cfg);
			default:        w = WRAP_NONE;
		endcase
		res.tc = t;
		res.wrap_level = w;
	end

endmodule

// File: sv/stc_outq.sv
// Two-entry result queue that decouples the state update from the output side.
module stc_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stc_pkg::res_t push_data,
	output logic          full,
	output logic          valid,
	input  logic          pop,
	output stc_pkg::res_t pop_data
);
	import stc_pkg::*;

	res_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/smpte_timecode_counter.sv
// An accepted request is registered, then its result is queued in the result queue.
// Throughput: one request per cycle while the result queue is not full; tc_q feeds back.
// A two-entry result queue keeps input accepted while a result waits.
// Reset: timecode clears to +00:00:00:00.00, queue empties, registers
// return to 30 fps, no drop-frame, 80 subframes per frame.
module smpte_timecode_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// hours[7:0], minutes[13:8], seconds[19:14], frames[25:20],
	// subframes[33:26], negative[34], zero[39:35]
	input  logic [39:0] s_axis_tdata,
	// kind[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// hours[7:0], minutes[13:8], seconds[19:14], frames[25:20],
	// subframes[33:26], negative[34], wrap_level[37:35], zero[39:38]
	output logic [39:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import stc_pkg::*;

	cfg_t  cfg;
	logic  valid_s1;
	kind_t kind_s1;
	tc_t   load_s1;
	tc_t   tc_q;
	res_t  step_res;
	res_t  out_res;
	logic  q_full;
	logic  advance;
	logic  in_accept;

	assign advance       = valid_s1 && !q_full;
	assign s_axis_tready = !valid_s1 || !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	stc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1           <= kind_t'(s_axis_tuser);
			load_s1.hours     <= s_axis_tdata[7:0];
			load_s1.minutes   <= s_axis_tdata[13:8];
			load_s1.seconds   <= s_axis_tdata[19:14];
			load_s1.frames    <= s_axis_tdata[25:20];
			load_s1.subframes <= s_axis_tdata[33:26];
			load_s1.negative  <= s_axis_tdata[34];
		end
	end

	stc_step u_step (
		.kind     (kind_s1),
		.load_val (load_s1),
		.cur      (tc_q),
		.cfg      (cfg),
		.res      (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
		end else if (advance) begin
			tc_q <= step_res.tc;
		end
	end

	stc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (step_res),
		.full      (q_full),
		.valid     (m_axis_tvalid),
		.pop       (m_axis_tvalid && m_axis_tready),
		.pop_data  (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.wrap_level, out_res.tc.negative,
		out_res.tc.subframes, out_res.tc.frames, out_res.tc.seconds,
		out_res.tc.minutes, out_res.tc.hours};

endmodule

// File: sv/stc_check.sv
// Port-level checker for the timecode counter and its bind statement.
`include "smpte_timecode_counter_defines.svh"

module stc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// The input side only stalls while results are waiting to be taken.
	`STC_ASSERT_NOW(a_stall_needs_result, !s_axis_tready, m_axis_tvalid)

	// Wrap level never exceeds the hours code.
	`STC_ASSERT_NOW(a_wrap_range, m_axis_tvalid, m_axis_tdata[37:35] <= 3'd4)

	// The padding above the wrap level stays clear.
	`STC_ASSERT_NOW(a_pad_clear, m_axis_tvalid, m_axis_tdata[39:38] == 2'b00)

	`STC_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	`STC_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind smpte_timecode_counter stc_check u_stc_check (.*);

// File: bench/tb.sv
// Self-checking testbench for smpte_timecode_counter: directed table, then random requests.
`timescale 1ns / 1ps

module tb;
	import stc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL = 300;
	localparam int SEG_ITEMS = 45;
	localparam int SEG_COUNT = 8;

	localparam cfg_t CFG_STD = {RST_RATE_CLASS, RST_DROP_FRAME, RST_SUBFRAMES};
	localparam cfg_t CFG_DROP = {2'd2, 1'b1, 8'd80};
	localparam cfg_t CFG_DROP25 = {2'd1, 1'b1, 8'd80};
	localparam cfg_t CFG_NOSUB = {2'd0, 1'b0, 8'd0};
	localparam cfg_t CFG_WIDE = {2'd3, 1'b0, 8'd255};

	typedef struct {
		cfg_t       cfg;
		kind_t      kind;
		tc_t        ld;
		bit         typed;
		tc_t        want_tc;
		logic [2:0] want_wrap;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// hours[7:0], minutes[13:8], seconds[19:14], frames[25:20],
	// subframes[33:26], negative[34], zero[39:35]
	logic [39:0] s_axis_tdata;
	// kind[2:0]
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// hours[7:0], minutes[13:8], seconds[19:14], frames[25:20],
	// subframes[33:26], negative[34], wrap_level[37:35], zero[39:38]
	logic [39:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	res_t awaited_results[$];
	int   mismatches;
	int   src_idle_pct;
	int   sink_idle_pct;
	bit   want_long_stall;
	bit   long_stall_done;
	int   stall_cycles;
	int   cycle_count;

	cfg_t       cfg_now;
	logic [7:0] tc_hr;
	logic [5:0] tc_min;
	logic [5:0] tc_sec;
	logic [5:0] tc_frm;
	logic [7:0] tc_sub;
	logic       tc_neg;

	smpte_timecode_counter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [5:0] top_frame();
		case (cfg_now.rate_class)
			2'd0: return 6'd23;
			2'd1: return 6'd24;
			2'd2: return 6'd29;
			default: return 6'd59;
		endcase
	endfunction

	function automatic bit drop_on();
		return cfg_now.drop_frame && cfg_now.rate_class == RATE_30;
	endfunction

	function automatic bit all_zero();
		return {tc_hr, tc_min, tc_sec, tc_frm, tc_sub} == '0;
	endfunction

	function automatic bit frames_zero();
		return {tc_hr, tc_min, tc_sec, tc_frm} == '0;
	endfunction

	function automatic logic [2:0] mag_inc();
		if (tc_frm < top_frame()) begin
			tc_frm = tc_frm + 6'd1;
			return WRAP_NONE;
		end
		if (tc_sec >= LAST_SECOND && tc_min >= LAST_MINUTE && tc_hr == LAST_HOUR)
			return WRAP_NONE;
		tc_frm = (drop_on() && ((int'(tc_min) + 1) % 10) != 0 && tc_sec >= LAST_SECOND)
			? DROP_COUNT : 6'd0;
		if (tc_sec < LAST_SECOND) begin
			tc_sec = tc_sec + 6'd1;
			return WRAP_SECONDS;
		end
		tc_sec = 6'd0;
		if (tc_min < LAST_MINUTE) begin
			tc_min = tc_min + 6'd1;
			return WRAP_MINUTES;
		end
		tc_min = 6'd0;
		tc_hr = tc_hr + 8'd1;
		return WRAP_HOURS;
	endfunction

	function automatic logic [2:0] mag_dec();
		bit carry;
		carry = 1'b0;
		if (drop_on() && (int'(tc_min) % 10) != 0 && tc_sec == 6'd0) begin
			if (tc_frm <= DROP_COUNT) begin
				tc_frm = DROP_LAST;
				carry = 1'b1;
			end
		end else if (tc_frm == 6'd0) begin
			tc_frm = top_frame();
			carry = 1'b1;
		end
		if (!carry) begin
			tc_frm = tc_frm - 6'd1;
			return WRAP_NONE;
		end
		if (tc_sec != 6'd0) begin
			tc_sec = tc_sec - 6'd1;
			return WRAP_SECONDS;
		end
		tc_sec = LAST_SECOND;
		if (tc_min != 6'd0) begin
			tc_min = tc_min - 6'd1;
			return WRAP_MINUTES;
		end
		tc_min = LAST_MINUTE;
		tc_hr = tc_hr - 8'd1;
		return WRAP_HOURS;
	endfunction

	function automatic logic [2:0] frame_inc();
		logic [2:0] w;
		if (!tc_neg)
			return mag_inc();
		if (frames_zero() && tc_sub != 8'd0) begin
			tc_sub = cfg_now.subframe_span - tc_sub;
			tc_neg = 1'b0;
			return WRAP_SECONDS;
		end
		if (all_zero()) begin
			w = mag_inc();
			tc_neg = 1'b1;
			return w;
		end
		w = mag_dec();
		tc_neg = !all_zero();
		return w;
	endfunction

	function automatic logic [2:0] frame_dec();
		logic [2:0] w;
		if (tc_neg || all_zero()) begin
			w = mag_inc();
			tc_neg = 1'b1;
			return w;
		end
		if (frames_zero() && tc_sub != 8'd0) begin
			tc_sub = cfg_now.subframe_span - tc_sub;
			tc_neg = 1'b1;
			return WRAP_SECONDS;
		end
		w = mag_dec();
		if (all_zero())
			tc_neg = 1'b0;
		return w;
	endfunction

	function automatic logic [2:0] sub_mag_inc();
		if (int'(tc_sub) + 1 >= int'(cfg_now.subframe_span)) begin
			tc_sub = 8'd0;
			void'(mag_inc());
			return WRAP_FRAMES;
		end
		tc_sub = tc_sub + 8'd1;
		return WRAP_NONE;
	endfunction

	function automatic logic [2:0] sub_mag_dec();
		if (tc_sub == 8'd0) begin
			if (all_zero()) begin
				tc_neg = 1'b1;
				tc_sub = 8'd1;
				return WRAP_FRAMES;
			end
			void'(mag_dec());
			if (all_zero())
				tc_neg = 1'b0;
			tc_sub = cfg_now.subframe_span - 8'd1;
			return WRAP_FRAMES;
		end
		tc_sub = tc_sub - 8'd1;
		if (all_zero())
			tc_neg = 1'b0;
		return WRAP_NONE;
	endfunction

	function automatic logic [2:0] sub_inc();
		logic [2:0] w;
		if (!tc_neg)
			return sub_mag_inc();
		tc_neg = 1'b0;
		w = sub_mag_dec();
		if (!all_zero())
			tc_neg = 1'b1;
		return w;
	endfunction

	function automatic logic [2:0] sub_dec();
		logic [2:0] w;
		if (!tc_neg)
			return sub_mag_dec();
		tc_neg = 1'b0;
		w = sub_mag_inc();
		tc_neg = 1'b1;
		return w;
	endfunction

	function automatic void clear_subframes();
		tc_sub = 8'd0;
		if (all_zero())
			tc_neg = 1'b0;
	endfunction

	function automatic void floor_to_second();
		clear_subframes();
		tc_frm = (drop_on() && (int'(tc_min) % 10) != 0 && tc_sec == 6'd0) ? DROP_COUNT : 6'd0;
		if (all_zero())
			tc_neg = 1'b0;
	endfunction

	function automatic logic [2:0] jump_second();
		logic [2:0] w;
		clear_subframes();
		if (tc_neg) begin
			w = frame_inc();
			floor_to_second();
			if (all_zero())
				tc_neg = 1'b0;
			return w;
		end
		tc_frm = top_frame();
		return mag_inc();
	endfunction

	function automatic logic [2:0] jump_minute();
		logic [2:0] w;
		clear_subframes();
		if (tc_neg) begin
			w = jump_second();
			tc_sec = 6'd0;
			floor_to_second();
			return w;
		end
		tc_sec = LAST_SECOND;
		return jump_second();
	endfunction

	function automatic logic [2:0] jump_hour();
		logic [2:0] w;
		clear_subframes();
		if (tc_neg) begin
			w = jump_minute();
			tc_min = 6'd0;
			tc_sec = 6'd0;
			tc_frm = 6'd0;
			tc_sub = 8'd0;
			if (all_zero())
				tc_neg = 1'b0;
			return w;
		end
		tc_min = LAST_MINUTE;
		return jump_minute();
	endfunction

	function automatic res_t apply_request(input kind_t k, input tc_t ld);
		res_t r;
		logic [2:0] w;
		w = WRAP_NONE;
		case (k)
			KIND_LOAD: begin
				tc_hr = ld.hours;
				tc_min = ld.minutes;
				tc_sec = ld.seconds;
				tc_frm = ld.frames;
				tc_sub = ld.subframes;
				tc_neg = ld.negative;
			end
			KIND_FRAME_UP: w = frame_inc();
			KIND_FRAME_DN: w = frame_dec();
			KIND_SUB_UP: w = sub_inc();
			KIND_SUB_DN: w = sub_dec();
			KIND_NEXT_SEC: w = jump_second();
			KIND_NEXT_MIN: w = jump_minute();
			default: w = jump_hour();
		endcase
		r.tc.hours = tc_hr;
		r.tc.minutes = tc_min;
		r.tc.seconds = tc_sec;
		r.tc.frames = tc_frm;
		r.tc.subframes = tc_sub;
		r.tc.negative = tc_neg;
		r.wrap_level = w;
		return r;
	endfunction

	function automatic tc_t mk_tc(input logic [7:0] h, input logic [5:0] m, s, f,
			input logic [7:0] sub, input logic neg);
		tc_t v;
		v.hours = h;
		v.minutes = m;
		v.seconds = s;
		v.frames = f;
		v.subframes = sub;
		v.negative = neg;
		return v;
	endfunction

	function automatic stim_row_t step_row(input cfg_t c, input kind_t k, input tc_t ld,
			input bit typed, input tc_t wt, input logic [2:0] ww);
		stim_row_t r;
		r.cfg = c;
		r.kind = k;
		r.ld = ld;
		r.typed = typed;
		r.want_tc = wt;
		r.want_wrap = ww;
		return r;
	endfunction

	function automatic tc_t rand_load();
		tc_t v;
		case ($urandom_range(0, 3))
			0: v.hours = 8'd0;
			1: v.hours = 8'd255;
			2: v.hours = 8'd254;
			default: v.hours = $urandom_range(0, 255);
		endcase
		case ($urandom_range(0, 3))
			0: v.minutes = 6'd0;
			1: v.minutes = 6'd9;
			2: v.minutes = 6'd59;
			default: v.minutes = $urandom_range(0, 59);
		endcase
		case ($urandom_range(0, 2))
			0: v.seconds = 6'd0;
			1: v.seconds = 6'd59;
			default: v.seconds = $urandom_range(0, 59);
		endcase
		case ($urandom_range(0, 5))
			0: v.frames = 6'd0;
			1: v.frames = top_frame();
			2: v.frames = top_frame() - 6'd1;
			3: v.frames = $urandom_range(0, 59);
			default: v.frames = $urandom_range(0, top_frame());
		endcase
		case ($urandom_range(0, 3))
			0: v.subframes = 8'd0;
			1: v.subframes = (cfg_now.subframe_span == 8'd0) ? 8'd0
				: cfg_now.subframe_span - 8'd1;
			2: v.subframes = $urandom_range(0, 3);
			default: v.subframes = $urandom_range(0, 254);
		endcase
		v.negative = $urandom_range(0, 1);
		if ($urandom_range(0, 3) == 0) begin
			v.hours = 8'd0;
			v.minutes = 6'd0;
			v.seconds = 6'd0;
			v.frames = $urandom_range(0, 2);
		end
		return v;
	endfunction

	task automatic send_req(input kind_t k, input tc_t ld, input bit typed, input res_t want);
		res_t r;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_axis_tdata <= {5'd0, ld.negative, ld.subframes, ld.frames, ld.seconds,
			ld.minutes, ld.hours};
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = apply_request(k, ld);
		awaited_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input cfg_t c);
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		apb_write(REG_RATE_CLASS, c.rate_class);
		apb_write(REG_DROP_FRAME, c.drop_frame);
		apb_write(REG_SUBFRAMES, c.subframe_span);
		cfg_now = c;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$error("result with no request waiting: %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("out_hours", want.tc.hours, m_axis_tdata[7:0]);
				check_field("out_minutes", want.tc.minutes, m_axis_tdata[13:8]);
				check_field("out_seconds", want.tc.seconds, m_axis_tdata[19:14]);
				check_field("out_frames", want.tc.frames, m_axis_tdata[25:20]);
				check_field("out_subframes", want.tc.subframes, m_axis_tdata[33:26]);
				check_field("out_negative", want.tc.negative, m_axis_tdata[34]);
				check_field("wrap_level", want.wrap_level, m_axis_tdata[37:35]);
			end
		end
	end

	// The receiver holds off once for a long stretch so the block fills and stalls its input.
	initial begin
		m_axis_tready = 1'b0;
		stall_cycles = 0;
		long_stall_done = 1'b0;
		forever begin
			@(negedge clk);
			if (want_long_stall && !long_stall_done) begin
				m_axis_tready <= 1'b0;
				stall_cycles++;
				if (stall_cycles >= LONG_STALL)
					long_stall_done = 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk) cycle_count++;
		$display("FAIL smpte_timecode_counter");
		$finish;
	end

	initial begin
		stim_row_t dir_rows[$];
		tc_t z;
		cfg_t c;
		kind_t k;
		int n;
		int run;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_LOAD;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		want_long_stall = 1'b0;
		mismatches = 0;
		src_idle_pct = 20;
		sink_idle_pct = 54;
		cfg_now = CFG_STD;
		tc_hr = '0;
		tc_min = '0;
		tc_sec = '0;
		tc_frm = '0;
		tc_sub = '0;
		tc_neg = 1'b0;
		z = mk_tc(0, 0, 0, 0, 0, 0);

		dir_rows.push_back(step_row(CFG_STD, KIND_FRAME_UP, z, 1, mk_tc(0, 0, 0, 1, 0, 0),
			WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_FRAME_DN, z, 1, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_FRAME_DN, z, 1, mk_tc(0, 0, 0, 1, 0, 1),
			WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_SUB_UP, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_LOAD, mk_tc(255, 59, 59, 29, 0, 0), 1,
			mk_tc(255, 59, 59, 29, 0, 0), WRAP_NONE));
		// Hours saturate: the up step leaves the count alone.
		dir_rows.push_back(step_row(CFG_STD, KIND_FRAME_UP, z, 1, mk_tc(255, 59, 59, 29, 0, 0),
			WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_NEXT_HOUR, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_LOAD, mk_tc(0, 0, 0, 0, 0, 1), 1,
			mk_tc(0, 0, 0, 0, 0, 1), WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_SUB_DN, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_LOAD, z, 1, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_SUB_DN, z, 1, mk_tc(0, 0, 0, 0, 1, 1),
			WRAP_FRAMES));
		dir_rows.push_back(step_row(CFG_STD, KIND_LOAD, mk_tc(0, 0, 59, 29, 79, 0), 1,
			mk_tc(0, 0, 59, 29, 79, 0), WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_SUB_UP, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_LOAD, mk_tc(1, 2, 3, 4, 5, 1), 1,
			mk_tc(1, 2, 3, 4, 5, 1), WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_NEXT_SEC, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_NEXT_MIN, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_NEXT_HOUR, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_LOAD, mk_tc(0, 0, 0, 59, 0, 0), 1,
			mk_tc(0, 0, 0, 59, 0, 0), WRAP_NONE));
		dir_rows.push_back(step_row(CFG_STD, KIND_FRAME_UP, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_DROP, KIND_LOAD, mk_tc(0, 0, 59, 29, 0, 0), 1,
			mk_tc(0, 0, 59, 29, 0, 0), WRAP_NONE));
		dir_rows.push_back(step_row(CFG_DROP, KIND_FRAME_UP, z, 1, mk_tc(0, 1, 0, 2, 0, 0),
			WRAP_MINUTES));
		dir_rows.push_back(step_row(CFG_DROP, KIND_FRAME_DN, z, 1, mk_tc(0, 0, 59, 29, 0, 0),
			WRAP_MINUTES));
		dir_rows.push_back(step_row(CFG_DROP25, KIND_LOAD, mk_tc(0, 0, 59, 24, 0, 0), 1,
			mk_tc(0, 0, 59, 24, 0, 0), WRAP_NONE));
		dir_rows.push_back(step_row(CFG_DROP25, KIND_FRAME_UP, z, 1, mk_tc(0, 1, 0, 0, 0, 0),
			WRAP_MINUTES));
		dir_rows.push_back(step_row(CFG_NOSUB, KIND_SUB_UP, z, 0, z, WRAP_NONE));
		dir_rows.push_back(step_row(CFG_WIDE, KIND_LOAD, mk_tc(0, 0, 0, 59, 254, 1), 1,
			mk_tc(0, 0, 0, 59, 254, 1), WRAP_NONE));
		dir_rows.push_back(step_row(CFG_WIDE, KIND_SUB_DN, z, 0, z, WRAP_NONE));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg != cfg_now)
				set_config(dir_rows[i].cfg);
			send_req(dir_rows[i].kind, dir_rows[i].ld, dir_rows[i].typed,
				{dir_rows[i].want_tc, dir_rows[i].want_wrap});
		end

		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg)
				0: c = {2'd0, 1'b0, 8'd1};
				1: c = CFG_DROP;
				2: c = {2'd3, 1'b1, 8'd255};
				3: c = {2'd1, 1'b1, 8'd25};
				4: c = {2'd2, 1'b1, 8'd2};
				5: begin
					c = CFG_STD;
					c.subframe_span = $urandom_range(1, 255);
				end
				6: begin
					c.rate_class = $urandom_range(0, 3);
					c.drop_frame = $urandom_range(0, 1);
					c.subframe_span = $urandom_range(1, 255);
				end
				default: c = {2'd2, 1'b1, 8'd100};
			endcase
			set_config(c);
			if (seg < 3) begin
				src_idle_pct = 20;
				sink_idle_pct = 54;
			end else if (seg < 6) begin
				src_idle_pct = 54;
				sink_idle_pct = 20;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			if (seg == 1)
				want_long_stall = 1'b1;
			n = 0;
			while (n < SEG_ITEMS) begin
				if ($urandom_range(0, 99) < 15) begin
					send_req(KIND_LOAD, rand_load(), 0, '0);
					n++;
				end else begin
					k = kind_t'($urandom_range(1, 7));
					run = $urandom_range(1, 10);
					repeat (run) begin
						send_req(k, rand_load(), 0, '0);
						n++;
					end
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS smpte_timecode_counter");
		else
			$display("FAIL smpte_timecode_counter");
		$finish;
	end

endmodule

// File: smpte_timecode_counter.f
+incdir+sv
sv/stc_pkg.sv
sv/stc_cfg.sv
sv/stc_step.sv
sv/stc_outq.sv
sv/smpte_timecode_counter.sv
sv/stc_check.sv
bench/tb.sv
